/* rtl/cht_pkg.sv */
`default_nettype none
package cht_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int KEY_BYTES       = 4;
  localparam int VALUE_BITS      = 32;
  localparam int KEY_W           = (KEY_BYTES * 8 > 32) ? 32 : KEY_BYTES * 8;
  localparam int VAL_W           = (VALUE_BITS > 32) ? 32 : VALUE_BITS;
  localparam int BCNT_W          = 3;
  localparam int HASH_W          = 64;
  localparam int SHIFT_LOW       = 6;
  localparam int SHIFT_HIGH      = 16;
  localparam logic [11:0] COUNT_MAX = 12'hFFF;

  localparam logic [31:0] SEED_RST  = 32'd5381;
  localparam logic [15:0] MULT_RST  = 16'd33;
  localparam logic [7:0]  KICKS_RST = 8'd32;

  localparam logic [1:0] CFG_SEED  = 2'd0;
  localparam logic [1:0] CFG_MULT  = 2'd1;
  localparam logic [1:0] CFG_KICKS = 2'd2;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam logic [2:0] STAT_STORED = 3'd0;
  localparam logic [2:0] STAT_DUP    = 3'd1;
  localparam logic [2:0] STAT_FULL   = 3'd2;
  localparam logic [2:0] STAT_HIT    = 3'd3;
  localparam logic [2:0] STAT_MISS   = 3'd4;

  typedef struct packed {
    logic        kind;
    logic [31:0] key;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] value_out;
    logic [31:0] dropped_key;
    logic [11:0] entry_count;
  } rsp_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HMUL,
    S_HADD,
    S_RED,
    S_READ,
    S_DECIDE,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

/* rtl/cuckoo_hash_table_top.sv */
// Two-way cuckoo hash table, one operation at a time.
// Request channel (req_valid/req_stall/req): kind selects insert or lookup;
// a beat is taken when req_valid is high and req_stall low. req_stall stays
// high from acceptance until the response beat has been taken.
// Response channel (rsp_valid/rsp_stall/rsp): one beat per request, held
// stable while rsp_stall is high; the next request waits for it.
// Hashing: the first hash works through each key byte on the shared
// 16x32 multiplier (two partial products, then combine), the second hash
// with a shift-add step per byte. Each hash then reduces modulo TABLE_DEPTH:
// by its low bits for a power-of-two depth, else by 16-bit digits, most
// significant first, each a reciprocal multiply and a correcting subtract.
// A lookup, duplicate or direct store hashes the key twice, reads both
// tables and decides; the next request can be taken in the cycle after
// the response beat. Every eviction adds the hash of the displaced key,
// its reduction, one read and one decide state.
// Reset: synchronous. Registers go to their defaults, the pair count to
// zero, then a clearing pass over all TABLE_DEPTH slots zeroes both valid maps
// while req_stall is held high; config writes are taken throughout.
`default_nettype none
module cuckoo_hash_table_top #(
  parameter int TABLE_DEPTH = cht_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         req_valid,
  output logic              req_stall,
  input  wire cht_pkg::req_t req,
  output logic              rsp_valid,
  input  wire logic         rsp_stall,
  output cht_pkg::rsp_t     rsp,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  import cht_pkg::*;

  localparam int  IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam bit  POW2 = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);
  localparam logic [IW:0]   DEPTH_X  = (IW + 1)'(TABLE_DEPTH);
  localparam logic [31:0]   RECIP    = 32'(64'h1_0000_0000 / TABLE_DEPTH);
  localparam logic [BCNT_W-1:0] LAST_BYTE = BCNT_W'(KEY_BYTES - 1);

  // configuration
  logic [31:0] hash_seed;
  logic [15:0] hash_mult;
  logic [7:0]  max_kicks;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_seed <= SEED_RST;
      hash_mult <= MULT_RST;
      max_kicks <= KICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SEED:  hash_seed <= cfg_data;
        CFG_MULT:  hash_mult <= cfg_data[15:0];
        CFG_KICKS: max_kicks <= cfg_data[7:0];
        default:   ;
      endcase
    end
  end

  // control and datapath registers
  state_t state, state_next;
  logic [IW-1:0]     clr_idx;
  logic              kind;
  logic              probe;     // first probe of both tables still pending
  logic              side;      // 0 table one, 1 table two
  logic              hsel;      // hash being computed: 0 first, 1 second
  logic [KEY_W-1:0]  ck;
  logic [VAL_W-1:0]  cv;
  logic [7:0]        kicks;
  logic [IW-1:0]     idx1, idx2;
  logic [HASH_W-1:0] h;
  logic [BCNT_W-1:0] bcnt;
  logic              mphase;
  logic [47:0]       plo;
  logic [31:0]       phi;
  logic [IW-1:0]     rem;
  logic [2:0]        rcnt;      // reduction step: digit in [2:1], multiply when [0] set
  logic [16:0]       rq;        // quotient estimate of the current digit
  logic [11:0]       pair_total;
  rsp_t              rsp_q;

  // tables
  logic             t1_vld [TABLE_DEPTH];
  logic [KEY_W-1:0] t1_key [TABLE_DEPTH];
  logic [VAL_W-1:0] t1_val [TABLE_DEPTH];
  logic             t2_vld [TABLE_DEPTH];
  logic [KEY_W-1:0] t2_key [TABLE_DEPTH];
  logic [VAL_W-1:0] t2_val [TABLE_DEPTH];
  logic             rd1_vld, rd2_vld;
  logic [KEY_W-1:0] rd1_key, rd2_key;
  logic [VAL_W-1:0] rd1_val, rd2_val;

  logic          wr1, wr2, wr_vld;
  logic [IW-1:0] wa1, wa2;

  always_ff @(posedge clk) begin
    if (wr1) begin
      t1_vld[wa1] <= wr_vld;
    end
    if (wr1 && !(state == S_CLEAR)) begin
      t1_key[wa1] <= ck;
      t1_val[wa1] <= cv;
    end
    rd1_vld <= t1_vld[idx1];
    rd1_key <= t1_key[idx1];
    rd1_val <= t1_val[idx1];
  end

  always_ff @(posedge clk) begin
    if (wr2) begin
      t2_vld[wa2] <= wr_vld;
    end
    if (wr2 && !(state == S_CLEAR)) begin
      t2_key[wa2] <= ck;
      t2_val[wa2] <= cv;
    end
    rd2_vld <= t2_vld[idx2];
    rd2_key <= t2_key[idx2];
    rd2_val <= t2_val[idx2];
  end

  // shared hash unit
  logic [HASH_W-1:0] key64;
  logic [HASH_W-1:0] kshift;
  logic [7:0]        kbyte;
  logic [31:0]       mop;
  logic [47:0]       prod;
  logic [HASH_W-1:0] h1_next, h2_next;
  logic [15:0]       rdig;
  logic [31:0]       rx;
  logic [63:0]       rprod;
  logic [32:0]       rsub;
  logic [IW-1:0]     rstep;
  logic [IW-1:0]     hres;
  logic              red_done;

  assign key64   = HASH_W'(ck);
  assign kshift  = key64 >> {bcnt, 3'b000};
  assign kbyte   = kshift[7:0];
  assign mop     = mphase ? h[63:32] : h[31:0];
  assign prod    = {32'd0, hash_mult} * {16'd0, mop};
  assign h1_next = ({phi, 32'd0} + {16'd0, plo}) ^ HASH_W'(kbyte);
  assign h2_next = HASH_W'(kbyte) + (h << SHIFT_LOW) + (h << SHIFT_HIGH) - h;
  // remainder by digits: x = rem:digit, q ~ x/D by reciprocal, x - q*D < 2D
  assign rdig    = h[{rcnt[2:1], 4'b0000} +: 16];
  assign rx      = {16'(rem), rdig};
  assign rprod   = 64'(rx) * 64'(RECIP);
  assign rsub    = {1'b0, rx} - 33'(rq) * 33'(DEPTH_X);
  assign rstep   = (rsub >= 33'(DEPTH_X)) ? IW'(rsub - 33'(DEPTH_X)) : IW'(rsub);
  assign hres    = POW2 ? h[IW-1:0] : rstep;
  assign red_done = POW2 || (rcnt == 3'd0);

  // decide
  logic             hit1, hit2, slot_vld, at_limit, dup_or_look;
  logic [KEY_W-1:0] slot_key;
  logic [VAL_W-1:0] slot_val;

  assign hit1        = rd1_vld && (rd1_key == ck);
  assign hit2        = rd2_vld && (rd2_key == ck);
  assign slot_vld    = side ? rd2_vld : rd1_vld;
  assign slot_key    = side ? rd2_key : rd1_key;
  assign slot_val    = side ? rd2_val : rd1_val;
  assign at_limit    = kicks >= max_kicks;
  assign dup_or_look = probe && (kind == KIND_LOOKUP || hit1 || hit2);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (clr_idx == LAST_IDX) state_next = S_IDLE;
      S_IDLE:   if (req_valid) state_next = S_HMUL;
      S_HMUL:   if (mphase) state_next = S_HADD;
      S_HADD: begin
        if (bcnt == LAST_BYTE) state_next = S_RED;
        else if (!hsel) state_next = S_HMUL;
      end
      S_RED: begin
        if (red_done) begin
          if (probe && !hsel) state_next = S_HADD;
          else state_next = S_READ;
        end
      end
      S_READ:   state_next = S_DECIDE;
      S_DECIDE: begin
        if (dup_or_look || !slot_vld || at_limit) state_next = S_OUT;
        else if (side) state_next = S_HMUL;
        else state_next = S_HADD;
      end
      S_OUT:    if (!rsp_stall) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs and table writes
  always_comb begin
    req_stall = 1'b1;
    rsp_valid = 1'b0;
    wr1       = 1'b0;
    wr2       = 1'b0;
    wr_vld    = 1'b1;
    wa1       = idx1;
    wa2       = idx2;
    unique case (state)
      S_CLEAR: begin
        wr1    = 1'b1;
        wr2    = 1'b1;
        wr_vld = 1'b0;
        wa1    = clr_idx;
        wa2    = clr_idx;
      end
      S_IDLE:  req_stall = 1'b0;
      S_DECIDE: begin
        if (!dup_or_look && !(slot_vld && at_limit)) begin
          wr1 = !side;
          wr2 = side;
        end
      end
      S_OUT:   rsp_valid = 1'b1;
      default: ;
    endcase
  end

  assign rsp = rsp_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      pair_total <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_CLEAR: clr_idx <= clr_idx + 1'b1;
        S_IDLE: begin
          if (req_valid) begin
            kind   <= req.kind;
            ck     <= req.key[KEY_W-1:0];
            cv     <= req.value[VAL_W-1:0];
            probe  <= 1'b1;
            side   <= 1'b0;
            hsel   <= 1'b0;
            kicks  <= '0;
            h      <= HASH_W'(hash_seed);
            bcnt   <= '0;
            mphase <= 1'b0;
          end
        end
        S_HMUL: begin
          if (!mphase) plo <= prod;
          else phi <= prod[31:0];
          mphase <= !mphase;
        end
        S_HADD: begin
          h <= hsel ? h2_next : h1_next;
          if (bcnt == LAST_BYTE) begin
            rem  <= '0;
            rcnt <= 3'd7;
          end else begin
            bcnt <= bcnt + 1'b1;
          end
        end
        S_RED: begin
          if (red_done) begin
            if (!hsel) idx1 <= hres;
            else idx2 <= hres;
            if (probe && !hsel) begin
              hsel <= 1'b1;
              h    <= '0;
              bcnt <= '0;
            end
          end else begin
            if (rcnt[0]) rq <= rprod[48:32];
            else rem <= rstep;
            rcnt <= rcnt - 1'b1;
          end
        end
        S_DECIDE: begin
          rsp_q.entry_count <= pair_total;
          rsp_q.value_out   <= '0;
          rsp_q.dropped_key <= '0;
          if (probe && kind == KIND_LOOKUP) begin
            rsp_q.status    <= (hit1 || hit2) ? STAT_HIT : STAT_MISS;
            rsp_q.value_out <= hit1 ? 32'(rd1_val) : (hit2 ? 32'(rd2_val) : 32'd0);
          end else if (dup_or_look) begin
            rsp_q.status <= STAT_DUP;
          end else if (!slot_vld) begin
            rsp_q.status <= STAT_STORED;
            if (pair_total != COUNT_MAX) begin
              pair_total        <= pair_total + 1'b1;
              rsp_q.entry_count <= pair_total + 1'b1;
            end
          end else if (at_limit) begin
            rsp_q.status      <= STAT_FULL;
            rsp_q.value_out   <= 32'(cv);
            rsp_q.dropped_key <= 32'(ck);
          end else begin
            ck     <= slot_key;
            cv     <= slot_val;
            kicks  <= kicks + 1'b1;
            side   <= !side;
            hsel   <= !side;
            probe  <= 1'b0;
            h      <= side ? HASH_W'(hash_seed) : '0;
            bcnt   <= '0;
            mphase <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // checks
  a_busy_while_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> req_stall)
    else $error("request taken while a response is pending");

  a_count_monotone: assert property (@(posedge clk) disable iff (rst)
    !rst |=> pair_total >= $past(pair_total))
    else $error("pair count went down");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == S_HMUL))
    else $error("accepted request did not start hashing");

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cht_pkg::*;

  localparam int DEPTH      = 1024;
  localparam int IDLE_LIMIT = 60000;  // worst insert at 255 kicks plus the long hold
  localparam int HOLD_LEN   = 3000;
  localparam int POOL_N     = 512;
  localparam int PHASE_N    = 460;

  logic  clk;
  logic  rst;
  logic  req_valid;
  logic  req_stall;
  req_t  req;
  logic  rsp_valid;
  logic  rsp_stall;
  rsp_t  rsp;
  logic  cfg_we;
  logic  [1:0] cfg_index;
  logic  [31:0] cfg_data;

  cuckoo_hash_table_top u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // Shadow of the table: config, both ways, pair count.
  // ---------------------------------------------------------------
  logic [31:0] sh_seed;
  logic [15:0] sh_mult;
  logic [7:0]  sh_kicks;
  bit          way1_v [DEPTH];
  logic [31:0] way1_k [DEPTH];
  logic [31:0] way1_d [DEPTH];
  bit          way2_v [DEPTH];
  logic [31:0] way2_k [DEPTH];
  logic [31:0] way2_d [DEPTH];
  logic [11:0] pairs_held;

  rsp_t        rsp_expected_q[$];
  int          errors;
  bit          hold_req;
  int          burst_left;
  logic [31:0] key_pool [POOL_N];

  // multiply-xor hash, 64-bit wrap, low bits select the way-one slot
  function automatic logic [9:0] slot_one(logic [31:0] k);
    logic [63:0] h;
    h = {32'd0, sh_seed};
    for (int i = 0; i < 4; i++) h = ({48'd0, sh_mult} * h) ^ {56'd0, k[8*i +: 8]};
    return h[9:0];
  endfunction

  // shift-add hash for way two
  function automatic logic [9:0] slot_two(logic [31:0] k);
    logic [63:0] h;
    h = 64'd0;
    for (int i = 0; i < 4; i++)
      h = {56'd0, k[8*i +: 8]} + (h << SHIFT_LOW) + (h << SHIFT_HIGH) - h;
    return h[9:0];
  endfunction

  // apply one operation to the shadow table and return what the block should answer
  function automatic rsp_t table_apply(req_t r);
    rsp_t        o;
    logic [9:0]  a1, a2, ix;
    logic [31:0] ck, cv, tk, tv;
    int          kicks;
    bit          side2;
    bit          done;
    o  = '0;
    a1 = slot_one(r.key);
    a2 = slot_two(r.key);
    if (r.kind == KIND_LOOKUP) begin
      if (way1_v[a1] && way1_k[a1] == r.key) begin
        o.status = STAT_HIT; o.value_out = way1_d[a1];
      end else if (way2_v[a2] && way2_k[a2] == r.key) begin
        o.status = STAT_HIT; o.value_out = way2_d[a2];
      end else begin
        o.status = STAT_MISS;
      end
    end else if ((way1_v[a1] && way1_k[a1] == r.key) ||
                 (way2_v[a2] && way2_k[a2] == r.key)) begin
      o.status = STAT_DUP;
    end else begin
      ck = r.key; cv = r.value; kicks = 0; side2 = 1'b0; done = 1'b0;
      while (!done) begin
        ix = side2 ? slot_two(ck) : slot_one(ck);
        if (!(side2 ? way2_v[ix] : way1_v[ix])) begin
          if (side2) begin
            way2_v[ix] = 1'b1; way2_k[ix] = ck; way2_d[ix] = cv;
          end else begin
            way1_v[ix] = 1'b1; way1_k[ix] = ck; way1_d[ix] = cv;
          end
          if (pairs_held != COUNT_MAX) pairs_held++;
          o.status = STAT_STORED;
          done = 1'b1;
        end else if (kicks >= sh_kicks) begin
          o.status = STAT_FULL; o.value_out = cv; o.dropped_key = ck;
          done = 1'b1;
        end else begin
          if (side2) begin
            tk = way2_k[ix]; tv = way2_d[ix]; way2_k[ix] = ck; way2_d[ix] = cv;
          end else begin
            tk = way1_k[ix]; tv = way1_d[ix]; way1_k[ix] = ck; way1_d[ix] = cv;
          end
          ck = tk; cv = tv;
          kicks++;
          side2 = ~side2;
        end
      end
    end
    o.entry_count = pairs_held;
    return o;
  endfunction

  // next key above k that lands on the same way-one slot
  function automatic logic [31:0] slot_one_twin(logic [31:0] k);
    logic [31:0] k2;
    k2 = k + 32'd1;
    while (slot_one(k2) != slot_one(k)) k2++;
    return k2;
  endfunction

  // ---------------------------------------------------------------
  // Request side: offer one beat, hold it until taken, then maybe gap.
  // ---------------------------------------------------------------
  task automatic send_op(req_t r, bit typed, rsp_t typed_rsp);
    rsp_t p;
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!(req_valid && !req_stall));
    p = table_apply(r);
    rsp_expected_q.push_back(typed ? typed_rsp : p);
    if (burst_left == 0) begin
      req_valid  <= 1'b0;
      burst_left = $urandom_range(0, 20);
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // registers change only with nothing in flight
  task automatic write_reg(logic [1:0] idx, logic [31:0] d);
    req_valid <= 1'b0;
    while (rsp_expected_q.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_SEED:  sh_seed  = d;
      CFG_MULT:  sh_mult  = d[15:0];
      CFG_KICKS: sh_kicks = d[7:0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------
  // Directed table. A row is either a register write or one beat;
  // 'twin' swaps the key for one sharing its way-one slot.
  // ---------------------------------------------------------------
  typedef struct {
    bit          is_cfg;
    logic [1:0]  idx;
    logic [31:0] data;
    req_t        op;
    bit          twin;
    bit          typed;
    rsp_t        exp;
  } row_t;

  row_t rows[$];

  function automatic row_t op_row(logic kind, logic [31:0] k, logic [31:0] v, bit tw);
    row_t rr;
    rr = '{default: '0};
    rr.op = '{kind: kind, key: k, value: v};
    rr.twin = tw;
    return rr;
  endfunction

  function automatic row_t typed_row(logic kind, logic [31:0] k, logic [31:0] v,
                                     logic [2:0] st, logic [31:0] vo, logic [11:0] cnt);
    row_t rr;
    rr = op_row(kind, k, v, 1'b0);
    rr.typed = 1'b1;
    rr.exp = '{status: st, value_out: vo, dropped_key: 32'd0, entry_count: cnt};
    return rr;
  endfunction

  function automatic row_t cfg_row(logic [1:0] idx, logic [31:0] d);
    row_t rr;
    rr = '{default: '0};
    rr.is_cfg = 1'b1; rr.idx = idx; rr.data = d;
    return rr;
  endfunction

  task automatic run_directed();
    rsp_t none;
    req_t r;
    none = '0;
    // empty table right after reset
    rows.push_back(typed_row(KIND_LOOKUP, 32'h0, 32'h0, STAT_MISS, 32'h0, 12'd0));
    rows.push_back(typed_row(KIND_INSERT, 32'h0, 32'hFFFF_FFFF, STAT_STORED, 32'h0, 12'd1));
    rows.push_back(typed_row(KIND_INSERT, 32'h0, 32'h5, STAT_DUP, 32'h0, 12'd1));
    // lookup ignores its value field
    rows.push_back(typed_row(KIND_LOOKUP, 32'h0, 32'hDEAD_BEEF, STAT_HIT, 32'hFFFF_FFFF, 12'd1));
    rows.push_back(op_row(KIND_INSERT, 32'hFFFF_FFFF, 32'h0, 1'b0));
    rows.push_back(op_row(KIND_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    rows.push_back(op_row(KIND_LOOKUP, 32'h1234_5678, 32'h0, 1'b0));
    // no evictions allowed: a taken way-one slot drops the new pair
    rows.push_back(cfg_row(CFG_KICKS, 32'd0));
    rows.push_back(op_row(KIND_INSERT, 32'h0, 32'hAAAA_5555, 1'b1));
    // one eviction: key 0 moves to way two
    rows.push_back(cfg_row(CFG_KICKS, 32'd1));
    rows.push_back(op_row(KIND_INSERT, 32'h0, 32'h5555_AAAA, 1'b1));
    rows.push_back(op_row(KIND_LOOKUP, 32'h0, 32'h0, 1'b0));
    rows.push_back(op_row(KIND_INSERT, 32'h0, 32'h0F0F_0F0F, 1'b1));
    // zero multiplier: slot follows the top key byte only
    rows.push_back(cfg_row(CFG_MULT, 32'd0));
    rows.push_back(cfg_row(CFG_KICKS, 32'd0));
    rows.push_back(op_row(KIND_INSERT, 32'h0100_0000, 32'h1, 1'b0));
    rows.push_back(op_row(KIND_INSERT, 32'h01AB_CDEF, 32'h2, 1'b0));
    rows.push_back(op_row(KIND_INSERT, 32'h01FF_FFFF, 32'h3, 1'b0));
    rows.push_back(op_row(KIND_LOOKUP, 32'h0100_0000, 32'h0, 1'b0));
    // register extremes
    rows.push_back(cfg_row(CFG_SEED, 32'hFFFF_FFFF));
    rows.push_back(cfg_row(CFG_MULT, 32'h0000_FFFF));
    rows.push_back(cfg_row(CFG_KICKS, 32'h0000_00FF));
    rows.push_back(op_row(KIND_INSERT, 32'h8000_0000, 32'h8000_0000, 1'b0));
    rows.push_back(op_row(KIND_LOOKUP, 32'h8000_0000, 32'h0, 1'b0));
    rows.push_back(cfg_row(CFG_SEED, 32'h0));
    rows.push_back(op_row(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0, 1'b0));
    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        r = rows[i].op;
        if (rows[i].twin) r.key = slot_one_twin(r.key);
        send_op(r, rows[i].typed, rows[i].typed ? rows[i].exp : none);
      end
    end
  endtask

  // mostly pool keys so inserts collide, repeat and get looked up
  task automatic run_random(int n);
    req_t r;
    rsp_t none;
    none = '0;
    for (int i = 0; i < n; i++) begin
      r.kind  = logic'($urandom_range(0, 1));
      r.key   = ($urandom_range(0, 99) < 75) ? key_pool[$urandom_range(0, POOL_N - 1)]
                                             : $urandom;
      r.value = $urandom;
      send_op(r, 1'b0, none);
    end
  endtask

  // ---------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------
  initial begin
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_SEED;
    cfg_data  <= '0;
    hold_req   = 1'b0;
    errors     = 0;
    burst_left = 0;
    sh_seed = SEED_RST; sh_mult = MULT_RST; sh_kicks = KICKS_RST;
    pairs_held = '0;
    for (int i = 0; i < DEPTH; i++) begin
      way1_v[i] = 1'b0; way2_v[i] = 1'b0;
    end
    for (int i = 0; i < POOL_N; i++)
      key_pool[i] = (i < 32) ? i : $urandom;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    run_directed();

    // random phases; the first one starts with the long receiver hold-off
    write_reg(CFG_SEED, $urandom);
    write_reg(CFG_MULT, $urandom_range(1, 16'hFFFF));
    write_reg(CFG_KICKS, $urandom_range(1, 8));
    hold_req = 1'b1;
    run_random(PHASE_N);

    write_reg(CFG_SEED, 32'd0);
    write_reg(CFG_MULT, 32'd1);
    write_reg(CFG_KICKS, 32'd32);
    run_random(PHASE_N);

    write_reg(CFG_SEED, 32'hFFFF_FFFF);
    write_reg(CFG_MULT, 32'd0);
    write_reg(CFG_KICKS, 32'd0);
    run_random(PHASE_N);

    write_reg(CFG_SEED, $urandom);
    write_reg(CFG_MULT, 32'h0000_FFFF);
    write_reg(CFG_KICKS, 32'd255);
    run_random(PHASE_N);

    req_valid <= 1'b0;
    while (rsp_expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // ---------------------------------------------------------------
  // Response side: stall pattern in stretches, plus one long hold.
  // ---------------------------------------------------------------
  initial begin
    int pct;
    rsp_stall <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        repeat (HOLD_LEN) begin
          @(posedge clk);
          rsp_stall <= 1'b1;
        end
        hold_req = 1'b0;
      end else begin
        case ($urandom_range(0, 2))
          0: pct = 0;
          1: pct = 30;
          default: pct = 75;
        endcase
        repeat ($urandom_range(20, 300)) begin
          @(posedge clk);
          rsp_stall <= ($urandom_range(0, 99) < pct);
        end
      end
    end
  end

  // compare each response beat against the oldest expectation
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (rsp_expected_q.size() == 0) begin
        $display("%0t: unexpected response beat %p", $realtime, rsp);
        errors++;
      end else begin
        e = rsp_expected_q.pop_front();
        if (rsp.status !== e.status) begin
          $display("%0t: status exp %0d got %0d", $realtime, e.status, rsp.status);
          errors++;
        end
        if (rsp.value_out !== e.value_out) begin
          $display("%0t: value_out exp %h got %h", $realtime, e.value_out, rsp.value_out);
          errors++;
        end
        if (rsp.dropped_key !== e.dropped_key) begin
          $display("%0t: dropped_key exp %h got %h", $realtime, e.dropped_key,
                   rsp.dropped_key);
          errors++;
        end
        if (rsp.entry_count !== e.entry_count) begin
          $display("%0t: entry_count exp %0d got %0d", $realtime, e.entry_count,
                   rsp.entry_count);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles with no beat on either channel
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, no beat for %0d cycles", $realtime, IDLE_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
`default_nettype wire

/* filelist.f */
rtl/cht_pkg.sv
rtl/cuckoo_hash_table_top.sv
tb/tb_top.sv
